// ----- hdl/si64alu_pkg.sv -----
package si64alu_pkg;

	typedef enum logic [3:0] {
		OP_EQ     = 4'd0,
		OP_NE     = 4'd1,
		OP_LT     = 4'd2,
		OP_GT     = 4'd3,
		OP_LE     = 4'd4,
		OP_GE     = 4'd5,
		OP_NEG    = 4'd6,
		OP_ADD    = 4'd7,
		OP_SUB    = 4'd8,
		OP_MUL    = 4'd9,
		OP_DIV    = 4'd10,
		OP_NARROW = 4'd11,
		OP_WIDEN  = 4'd12
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DIV_ZERO = 2'd1,
		ST_NARROW   = 2'd2,
		ST_DIV_OVF  = 2'd3
	} status_t;

endpackage

// ----- hdl/signed_int64_alu_top.sv -----
// signed 64-bit integer alu: one item per cycle, every opcode. From start to done an
// item passes the input capture, stage 1, the divider stages and the output register; the
// divider is a restoring array with one quotient bit per pipeline stage, and all other
// operations travel alongside it. busy is always low and each result shows on done for
// one cycle; the receiver cannot stall, so results must be taken as they come.
module signed_int64_alu_top #(
	parameter int DATA_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         opcode,
	input  logic signed [63:0] operand_a,
	input  logic signed [63:0] operand_b,
	output logic               done,
	output logic signed [63:0] value,
	output logic               compare_true,
	output logic [1:0]         status
);

	localparam int W = DATA_WIDTH;
	localparam int H = (DATA_WIDTH + 1) / 2;

	// stage 0: input capture
	logic         vld_s0;
	logic [3:0]   op_s0;
	logic [W-1:0] a_s0, b_s0;

	// stage 1: everything but the divider steps and the product sum
	logic          vld_s1, isdiv_s1, ismul_s1, qneg_s1, cmp_s1;
	logic [1:0]    st_s1;
	logic [W-1:0]  val_s1, ma_s1, mb_s1;
	logic [2*H-1:0] p0_s1;
	logic [H-1:0]  p1_s1, p2_s1;

	// divider stages
	logic         vld_sd   [0:W-1];
	logic         isdiv_sd [0:W-1];
	logic         qneg_sd  [0:W-1];
	logic         cmp_sd   [0:W-1];
	logic [1:0]   st_sd    [0:W-1];
	logic [W-1:0] val_sd   [0:W-1];
	logic [W-1:0] num_sd   [0:W-1];
	logic [W-1:0] rem_sd   [0:W-1];
	logic [W-1:0] dvs_sd   [0:W-1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s0 <= opcode;
		a_s0  <= operand_a[W-1:0];
		b_s0  <= operand_b[W-1:0];
	end

	logic [63:0]    a64;
	logic           slt, sgt, eq, narrow_ok, na, nb;
	logic [63:0]    wid64;
	logic [2*H-1:0] ax, bx;
	logic           cmp_c;
	logic [1:0]     st_c;
	logic [W-1:0]   val_c;

	always_comb begin
		a64       = 64'(signed'(a_s0));
		slt       = $signed(a_s0) < $signed(b_s0);
		sgt       = $signed(b_s0) < $signed(a_s0);
		eq        = a_s0 == b_s0;
		narrow_ok = (&a64[63:31]) | ~(|a64[63:31]);
		wid64     = {{32{a64[31]}}, a64[31:0]};
		na        = a_s0[W-1];
		nb        = b_s0[W-1];
		ax        = (2*H)'(a_s0);
		bx        = (2*H)'(b_s0);
		cmp_c     = 1'b0;
		st_c      = si64alu_pkg::ST_OK;
		val_c     = '0;
		case (op_s0)
			si64alu_pkg::OP_EQ:  cmp_c = eq;
			si64alu_pkg::OP_NE:  cmp_c = ~eq;
			si64alu_pkg::OP_LT:  cmp_c = slt;
			si64alu_pkg::OP_GT:  cmp_c = sgt;
			si64alu_pkg::OP_LE:  cmp_c = ~sgt;
			si64alu_pkg::OP_GE:  cmp_c = ~slt;
			si64alu_pkg::OP_NEG: val_c = W'(0) - a_s0;
			si64alu_pkg::OP_ADD: val_c = a_s0 + b_s0;
			si64alu_pkg::OP_SUB: val_c = a_s0 - b_s0;
			si64alu_pkg::OP_DIV: begin
				if (b_s0 == '0) begin
					st_c = si64alu_pkg::ST_DIV_ZERO;
				end else if (a_s0 == {1'b1, {(W-1){1'b0}}} && (&b_s0)) begin
					st_c = si64alu_pkg::ST_DIV_OVF;
				end
			end
			si64alu_pkg::OP_NARROW: begin
				if (narrow_ok) begin
					val_c = a_s0;
				end else begin
					st_c = si64alu_pkg::ST_NARROW;
				end
			end
			si64alu_pkg::OP_WIDEN: val_c = wid64[W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_s0;
		end
	end

	always_ff @(posedge clk) begin
		isdiv_s1 <= op_s0 == si64alu_pkg::OP_DIV;
		ismul_s1 <= op_s0 == si64alu_pkg::OP_MUL;
		qneg_s1  <= na ^ nb;
		cmp_s1   <= cmp_c;
		st_s1    <= st_c;
		val_s1   <= val_c;
		ma_s1    <= na ? W'(0) - a_s0 : a_s0;
		mb_s1    <= nb ? W'(0) - b_s0 : b_s0;
		// low product only needs the cross terms modulo 2^H
		p0_s1    <= ax[H-1:0] * bx[H-1:0];
		p1_s1    <= H'(ax[H-1:0] * bx[2*H-1:H]);
		p2_s1    <= H'(ax[2*H-1:H] * bx[H-1:0]);
	end

	logic [2*H-1:0] msum;
	assign msum = p0_s1 + {H'(p1_s1 + p2_s1), H'(0)};

	// one restoring step per stage, quotient bits shift in behind the dividend
	logic [W-1:0] rem_in [0:W-1];
	logic [W-1:0] num_in [0:W-1];
	logic [W-1:0] dvs_in [0:W-1];
	logic [W:0]   trial  [0:W-1];
	logic         qbit   [0:W-1];
	logic [W-1:0] rem_nx [0:W-1];

	always_comb begin
		for (int k = 0; k < W; k++) begin
			if (k == 0) begin
				rem_in[k] = '0;
				num_in[k] = ma_s1;
				dvs_in[k] = mb_s1;
			end else begin
				rem_in[k] = rem_sd[k-1];
				num_in[k] = num_sd[k-1];
				dvs_in[k] = dvs_sd[k-1];
			end
			trial[k] = {rem_in[k], num_in[k][W-1]};
			qbit[k]  = trial[k] >= {1'b0, dvs_in[k]};
			rem_nx[k] = qbit[k] ? W'(trial[k] - {1'b0, dvs_in[k]}) : trial[k][W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < W; k++) begin
				vld_sd[k] <= 1'b0;
			end
		end else begin
			vld_sd[0] <= vld_s1;
			for (int k = 1; k < W; k++) begin
				vld_sd[k] <= vld_sd[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		isdiv_sd[0] <= isdiv_s1;
		qneg_sd[0]  <= qneg_s1;
		cmp_sd[0]   <= cmp_s1;
		st_sd[0]    <= st_s1;
		val_sd[0]   <= ismul_s1 ? msum[W-1:0] : val_s1;
		for (int k = 1; k < W; k++) begin
			isdiv_sd[k] <= isdiv_sd[k-1];
			qneg_sd[k]  <= qneg_sd[k-1];
			cmp_sd[k]   <= cmp_sd[k-1];
			st_sd[k]    <= st_sd[k-1];
			val_sd[k]   <= val_sd[k-1];
		end
		for (int k = 0; k < W; k++) begin
			rem_sd[k] <= rem_nx[k];
			num_sd[k] <= {num_in[k][W-2:0], qbit[k]};
			dvs_sd[k] <= dvs_in[k];
		end
	end

	logic [W-1:0] q, fin;
	always_comb begin
		q = num_sd[W-1];
		if (isdiv_sd[W-1] && st_sd[W-1] == si64alu_pkg::ST_OK) begin
			fin = qneg_sd[W-1] ? W'(0) - q : q;
		end else begin
			fin = val_sd[W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_sd[W-1];
		end
	end

	always_ff @(posedge clk) begin
		value        <= 64'(signed'(fin));
		compare_true <= cmp_sd[W-1];
		status       <= st_sd[W-1];
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam int DW = 64;
	localparam int LATENCY = DW + 3;
	localparam longint unsigned MINV = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic signed [63:0] value;
		logic               compare_true;
		logic [1:0]         status;
	} alu_result_t;

	class alu_scoreboard;
		alu_result_t pending[$];
		int          mismatches;
		int          checked;

		function alu_result_t compute(logic [3:0] op, logic [63:0] a, logic [63:0] b);
			alu_result_t r;
			logic [63:0] ma, mb, q;
			r = '0;
			case (op)
				si64alu_pkg::OP_EQ: r.compare_true = (a == b);
				si64alu_pkg::OP_NE: r.compare_true = (a != b);
				si64alu_pkg::OP_LT: r.compare_true = ($signed(a) < $signed(b));
				si64alu_pkg::OP_GT: r.compare_true = ($signed(a) > $signed(b));
				si64alu_pkg::OP_LE: r.compare_true = ($signed(a) <= $signed(b));
				si64alu_pkg::OP_GE: r.compare_true = ($signed(a) >= $signed(b));
				si64alu_pkg::OP_NEG: r.value = 64'd0 - a;
				si64alu_pkg::OP_ADD: r.value = a + b;
				si64alu_pkg::OP_SUB: r.value = a - b;
				si64alu_pkg::OP_MUL: r.value = a * b;
				si64alu_pkg::OP_DIV: begin
					if (b == 0) begin
						r.status = si64alu_pkg::ST_DIV_ZERO;
					end else if (a == MINV && b == '1) begin
						r.status = si64alu_pkg::ST_DIV_OVF;
					end else begin
						ma = a[63] ? 64'd0 - a : a;
						mb = b[63] ? 64'd0 - b : b;
						q = ma / mb;
						r.value = (a[63] != b[63]) ? 64'd0 - q : q;
					end
				end
				si64alu_pkg::OP_NARROW: begin
					if (a + 64'h8000_0000 < 64'h1_0000_0000)
						r.value = a;
					else
						r.status = si64alu_pkg::ST_NARROW;
				end
				si64alu_pkg::OP_WIDEN: r.value = {{32{a[31]}}, a[31:0]};
				default: ;
			endcase
			return r;
		endfunction

		function void note_item(logic [3:0] op, logic [63:0] a, logic [63:0] b);
			pending.push_back(compute(op, a, b));
		endfunction

		function void check_result(alu_result_t got);
			alu_result_t exp;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result value=%h cmp=%b st=%0d", $time,
					got.value, got.compare_true, got.status);
				mismatches++;
				return;
			end
			exp = pending.pop_front();
			if (got.value !== exp.value) begin
				$display("%0t: value expected %h actual %h", $time, exp.value, got.value);
				mismatches++;
			end
			if (got.compare_true !== exp.compare_true) begin
				$display("%0t: compare_true expected %b actual %b", $time,
					exp.compare_true, got.compare_true);
				mismatches++;
			end
			if (got.status !== exp.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic [3:0]         opcode = '0;
	logic signed [63:0] operand_a = '0;
	logic signed [63:0] operand_b = '0;
	logic               done;
	logic signed [63:0] value;
	logic               compare_true;
	logic [1:0]         status;

	alu_scoreboard sb = new();
	bit            allow_idle = 1;
	int            sent;

	signed_int64_alu_top #(.DATA_WIDTH(DW)) uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk)
		if (done)
			sb.check_result('{value, compare_true, status});

	function automatic logic [63:0] rand_operand();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: v = MINV;
			1: v = MINV - 1;
			2: v = '1;
			3: v = 64'(signed'($urandom_range(0, 8)) - 4);
			4: v = {{32{v[31]}}, v[31:0]};
			5: v = 64'h7fff_ffff + 64'($urandom_range(0, 2)) - 1;
			6: v = 64'hffff_ffff_8000_0000 + 64'($urandom_range(0, 2)) - 1;
			7: v = {{48{v[15]}}, v[15:0]};
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_item(logic [3:0] op, logic [63:0] a, logic [63:0] b);
		int gap;
		if (allow_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		opcode <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(op, a, b);
		sent++;
	endtask

	initial begin
		int wait_cycles;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed corners
		for (int op = 0; op < 16; op++)
			send_item(4'(op), MINV, 64'h7fff_ffff_ffff_ffff);
		send_item(si64alu_pkg::OP_DIV, 64'd17, 64'd0);
		send_item(si64alu_pkg::OP_DIV, MINV, '1);
		send_item(si64alu_pkg::OP_DIV, -64'sd7, 64'sd2);
		send_item(si64alu_pkg::OP_NARROW, 64'h8000_0000, 0);
		send_item(si64alu_pkg::OP_NARROW, 64'hffff_ffff_8000_0000, 0);
		send_item(si64alu_pkg::OP_NARROW, 64'hffff_ffff_7fff_ffff, 0);
		send_item(si64alu_pkg::OP_WIDEN, 64'h1234_5678_8000_0001, 0);
		send_item(si64alu_pkg::OP_MUL, MINV, '1);
		send_item(si64alu_pkg::OP_EQ, '1, '1);
		for (int i = 0; i < 900; i++) begin
			if (i == 750) allow_idle = 0;
			send_item(4'($urandom_range(0, 15) < 14 ? $urandom_range(0, 12)
				: $urandom_range(13, 15)), rand_operand(), rand_operand());
		end
		start <= 0;
		wait_cycles = 0;
		while (sb.pending.size() != 0 && wait_cycles < 10 * LATENCY) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 5) @(posedge clk);
		$display("sent %0d items over all opcodes incl. unused codes, %0d results checked",
			sent, sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("signed_int64_alu_top test passed");
		else
			$display("signed_int64_alu_top test failed");
		$finish;
	end

	initial begin
		#200000;
		$display("signed_int64_alu_top test failed");
		$finish;
	end

endmodule
